// ===== rtl/core/dpbt_pkg.sv =====
// shared constants, widths and types of the depth pixel back-projection pipeline
package dpbt_pkg;

  // output coordinate format
  localparam int COORD_BITS = 12;
  localparam int COORD_W    = COORD_BITS + 8;

  // input field widths
  localparam int PIX_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int CHAN_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int ROT_W      = 16;
  localparam int SHIFT_W    = 24;
  localparam int RECIP_W    = 24;
  localparam int PP_W       = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSE_ROW_X        = 3'd0,
    CFG_POSE_ROW_Y        = 3'd1,
    CFG_POSE_ROW_Z        = 3'd2,
    CFG_SHIFT_X           = 3'd3,
    CFG_SHIFT_Y           = 3'd4,
    CFG_SHIFT_Z           = 3'd5,
    CFG_FOCAL_RECIPROCALS = 3'd6,
    CFG_PRINCIPAL_POINT   = 3'd7
  } cfg_reg_t;

  // identity pose after reset
  localparam logic [CFG_DATA_W-1:0] POSE_X_RST = 48'h0000_0000_4000;
  localparam logic [CFG_DATA_W-1:0] POSE_Y_RST = 48'h0000_4000_0000;
  localparam logic [CFG_DATA_W-1:0] POSE_Z_RST = 48'h4000_0000_0000;

  // depth limit: 10 m in Q4.12
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd40960;

  // camera-side arithmetic widths
  localparam int DU_W      = PIX_W + 6;             // 16*u - cx, signed
  localparam int PXD_W     = DU_W + DEPTH_W + 1;    // du * d
  localparam int RAW_W     = PXD_W + RECIP_W + 1;   // du * d * (1/f), 40 fraction bits
  localparam int CAM_RND   = 16;                    // 40 -> 24 fraction bits
  localparam int CAM_W     = 42;                    // camera x/y, Q.24 signed
  localparam int CAMZ_W    = DEPTH_W + 12;          // camera z, Q.24 unsigned

  // world-side arithmetic widths
  localparam int LO_W      = CAM_W / 2;             // low partial-product slice
  localparam int HI_W      = CAM_W - LO_W;
  localparam int PPL_W     = ROT_W + LO_W + 1;
  localparam int PPH_W     = ROT_W + HI_W;
  localparam int PPZ_W     = ROT_W + CAMZ_W + 1;
  localparam int ACC_FRAC  = 38;
  localparam int ACC_W     = 60;
  localparam int SHIFT_SCALE = ACC_FRAC - 12;       // Q12.12 translation into accumulator
  localparam int WORLD_SHIFT = ACC_FRAC - COORD_BITS;
  localparam int WC_W      = ACC_W - WORLD_SHIFT;   // rounded coordinate before range check

  // stream payloads
  localparam int S_TDATA_W = 64;
  localparam int M_FIELD_W = 3 * COORD_W + 3 * CHAN_W;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  // per-pixel sideband carried beside the arithmetic
  typedef struct packed {
    logic              depth_ok;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } side_t;

endpackage

// ===== rtl/core/dpbt_world_row.sv =====
// one row of the rigid transform: rotation dot product plus translation, three stages
module dpbt_world_row (
  input  logic                                  clk,
  input  logic                                  ce,
  input  logic [dpbt_pkg::CFG_DATA_W-1:0]       pose_row,
  input  logic signed [dpbt_pkg::SHIFT_W-1:0]   shift,
  input  logic signed [dpbt_pkg::CAM_W-1:0]     cam_x,
  input  logic signed [dpbt_pkg::CAM_W-1:0]     cam_y,
  input  logic [dpbt_pkg::CAMZ_W-1:0]           cam_z,
  output logic signed [dpbt_pkg::ACC_W-1:0]     acc
);
  import dpbt_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (WORLD_SHIFT - 1);

  logic signed [ROT_W-1:0] r0, r1, r2;
  logic signed [PPL_W-1:0] ppl_x, ppl_y;
  logic signed [PPH_W-1:0] pph_x, pph_y;
  logic signed [PPZ_W-1:0] pp_z;
  logic signed [ACC_W-1:0] col_x, col_y, col_zt;

  assign r0 = $signed(pose_row[0*ROT_W +: ROT_W]);
  assign r1 = $signed(pose_row[1*ROT_W +: ROT_W]);
  assign r2 = $signed(pose_row[2*ROT_W +: ROT_W]);

  // partial products, camera x/y split in two halves
  always_ff @(posedge clk) begin
    if (ce) begin
      ppl_x <= PPL_W'(r0) * PPL_W'($signed({1'b0, cam_x[LO_W-1:0]}));
      pph_x <= PPH_W'(r0) * PPH_W'($signed(cam_x[CAM_W-1:LO_W]));
      ppl_y <= PPL_W'(r1) * PPL_W'($signed({1'b0, cam_y[LO_W-1:0]}));
      pph_y <= PPH_W'(r1) * PPH_W'($signed(cam_y[CAM_W-1:LO_W]));
      pp_z  <= PPZ_W'(r2) * PPZ_W'($signed({1'b0, cam_z}));
    end
  end

  // recombine halves, fold in translation
  always_ff @(posedge clk) begin
    if (ce) begin
      col_x  <= (ACC_W'(pph_x) <<< LO_W) + ACC_W'(ppl_x);
      col_y  <= (ACC_W'(pph_y) <<< LO_W) + ACC_W'(ppl_y);
      col_zt <= ACC_W'(pp_z) + (ACC_W'(shift) <<< SHIFT_SCALE);
    end
  end

  // final sum with round-half-up offset
  always_ff @(posedge clk) begin
    if (ce) begin
      acc <= col_x + col_y + col_zt + ROUND_HALF;
    end
  end

endmodule

// ===== rtl/core/depth_pixel_backproject_transform.sv =====
// top level: depth pixel back-projection through a pinhole model and rigid pose transform
module depth_pixel_backproject_transform (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [dpbt_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [dpbt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // pixel requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // column[11:0], row[23:12], depth[39:24], blue_in[47:40], green_in[55:48], red_in[63:56]
  input  logic [dpbt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // point results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // world_x[19:0], world_y[39:20], world_z[59:40], red_out[67:60], green_out[75:68],
  // blue_out[83:76], zero fill[87:84]
  output logic [dpbt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // point_valid[0]
  output logic [0:0]                          m_axis_tuser
);
  // Accepts one pixel request per clock unless the output is stalled, and returns one point
  // per request, in order. The pipeline runs as a single chain: stage 1 forms
  // (16*u - cx) * depth, stage 2 multiplies by the focal reciprocal, stage 3 rounds to
  // camera coordinates, stages 4 to 6 form the rotation partial products, recombine them
  // with the translation and sum each world row, and stage 7 rounds to the output format,
  // applies the 100 m range check and holds the result in the output register. The whole
  // chain advances whenever the output register is empty or being taken, so the input is
  // ready in the same cycle a waiting result leaves. Invalid points (depth zero, depth over
  // 10 m, or any world coordinate beyond 100 m) come out with all fields zero and
  // point_valid clear. Configuration registers are sampled live by the pipeline and should
  // only be written while no pixel is in flight.
  import dpbt_pkg::*;

  localparam logic signed [WC_W-1:0] COORD_LIM     = WC_W'(100) <<< COORD_BITS;
  localparam logic signed [WC_W-1:0] COORD_LIM_NEG = -COORD_LIM;
  localparam logic signed [RAW_W-1:0] CAM_HALF     = RAW_W'(1) <<< (CAM_RND - 1);

  // configuration registers
  logic [CFG_DATA_W-1:0]     pose_row_x, pose_row_y, pose_row_z;
  logic signed [SHIFT_W-1:0] shift_x, shift_y, shift_z;
  logic [2*RECIP_W-1:0]      focal_reciprocals;
  logic [2*PP_W-1:0]         principal_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_row_x        <= POSE_X_RST;
      pose_row_y        <= POSE_Y_RST;
      pose_row_z        <= POSE_Z_RST;
      shift_x           <= '0;
      shift_y           <= '0;
      shift_z           <= '0;
      focal_reciprocals <= '0;
      principal_point   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POSE_ROW_X:        pose_row_x        <= cfg_wdata;
        CFG_POSE_ROW_Y:        pose_row_y        <= cfg_wdata;
        CFG_POSE_ROW_Z:        pose_row_z        <= cfg_wdata;
        CFG_SHIFT_X:           shift_x           <= $signed(cfg_wdata[SHIFT_W-1:0]);
        CFG_SHIFT_Y:           shift_y           <= $signed(cfg_wdata[SHIFT_W-1:0]);
        CFG_SHIFT_Z:           shift_z           <= $signed(cfg_wdata[SHIFT_W-1:0]);
        CFG_FOCAL_RECIPROCALS: focal_reciprocals <= cfg_wdata[2*RECIP_W-1:0];
        CFG_PRINCIPAL_POINT:   principal_point   <= cfg_wdata[2*PP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: output register empty or draining
  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // unpack the request
  logic [PIX_W-1:0]   in_col, in_row;
  logic [DEPTH_W-1:0] in_depth;
  side_t              in_side;

  assign in_col            = s_axis_tdata[11:0];
  assign in_row            = s_axis_tdata[23:12];
  assign in_depth          = s_axis_tdata[39:24];
  assign in_side.blue      = s_axis_tdata[47:40];
  assign in_side.green     = s_axis_tdata[55:48];
  assign in_side.red       = s_axis_tdata[63:56];
  assign in_side.depth_ok  = (in_depth != '0) && (in_depth <= DEPTH_MAX);

  // offsets from the principal point, Q12.4
  logic signed [DU_W-1:0] du, dv;
  assign du = $signed({2'b00, in_col, 4'b0000}) - $signed({2'b00, principal_point[PP_W-1:0]});
  assign dv = $signed({2'b00, in_row, 4'b0000})
            - $signed({2'b00, principal_point[2*PP_W-1:PP_W]});

  // valid bits and sideband for stages 1..6
  logic  vld  [1:6];
  side_t side [1:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 6; i++) vld[i] <= 1'b0;
    end else if (ce) begin
      vld[1] <= s_axis_tvalid;
      for (int i = 2; i <= 6; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[1] <= in_side;
      for (int i = 2; i <= 6; i++) side[i] <= side[i-1];
    end
  end

  // stage 1: offset times depth
  logic signed [PXD_W-1:0] pxd_x, pxd_y;
  logic [DEPTH_W-1:0]      depth1, depth2;

  always_ff @(posedge clk) begin
    if (ce) begin
      pxd_x  <= PXD_W'(du) * PXD_W'($signed({1'b0, in_depth}));
      pxd_y  <= PXD_W'(dv) * PXD_W'($signed({1'b0, in_depth}));
      depth1 <= in_depth;
    end
  end

  // stage 2: scale by focal reciprocal, 40 fraction bits
  logic signed [RAW_W-1:0] raw_x, raw_y;

  always_ff @(posedge clk) begin
    if (ce) begin
      raw_x  <= RAW_W'(pxd_x)
              * RAW_W'($signed({1'b0, focal_reciprocals[RECIP_W-1:0]}));
      raw_y  <= RAW_W'(pxd_y)
              * RAW_W'($signed({1'b0, focal_reciprocals[2*RECIP_W-1:RECIP_W]}));
      depth2 <= depth1;
    end
  end

  // stage 3: round to 24 fraction bits
  logic signed [RAW_W-1:0]  raw_x_rnd, raw_y_rnd;
  logic signed [CAM_W-1:0]  cam_x, cam_y;
  logic [CAMZ_W-1:0]        cam_z;

  assign raw_x_rnd = raw_x + CAM_HALF;
  assign raw_y_rnd = raw_y + CAM_HALF;

  always_ff @(posedge clk) begin
    if (ce) begin
      cam_x <= $signed(raw_x_rnd[CAM_RND +: CAM_W]);
      cam_y <= $signed(raw_y_rnd[CAM_RND +: CAM_W]);
      cam_z <= {depth2, 12'h000};
    end
  end

  // stages 4..6: one rotation row per world axis
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;

  dpbt_world_row u_row_x (
    .clk      (clk),
    .ce       (ce),
    .pose_row (pose_row_x),
    .shift    (shift_x),
    .cam_x    (cam_x),
    .cam_y    (cam_y),
    .cam_z    (cam_z),
    .acc      (acc_x)
  );

  dpbt_world_row u_row_y (
    .clk      (clk),
    .ce       (ce),
    .pose_row (pose_row_y),
    .shift    (shift_y),
    .cam_x    (cam_x),
    .cam_y    (cam_y),
    .cam_z    (cam_z),
    .acc      (acc_y)
  );

  dpbt_world_row u_row_z (
    .clk      (clk),
    .ce       (ce),
    .pose_row (pose_row_z),
    .shift    (shift_z),
    .cam_x    (cam_x),
    .cam_y    (cam_y),
    .cam_z    (cam_z),
    .acc      (acc_z)
  );

  // stage 7: drop fraction bits (half already added), range check, output register
  logic signed [WC_W-1:0] wx, wy, wz;
  logic                   in_range, point_ok;

  assign wx = $signed(acc_x[ACC_W-1:WORLD_SHIFT]);
  assign wy = $signed(acc_y[ACC_W-1:WORLD_SHIFT]);
  assign wz = $signed(acc_z[ACC_W-1:WORLD_SHIFT]);

  assign in_range = (wx <= COORD_LIM) && (wx >= COORD_LIM_NEG)
                 && (wy <= COORD_LIM) && (wy >= COORD_LIM_NEG)
                 && (wz <= COORD_LIM) && (wz >= COORD_LIM_NEG);
  assign point_ok = side[6].depth_ok && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (point_ok) begin
        m_axis_tdata <= {(M_TDATA_W - M_FIELD_W)'(0),
                         side[6].blue, side[6].green, side[6].red,
                         wz[COORD_W-1:0], wy[COORD_W-1:0], wx[COORD_W-1:0]};
        m_axis_tuser <= 1'b1;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the depth pixel back-projection and pose transform block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpbt_pkg::*;

  // camera x/y keep 40 fraction bits before rounding down to 24
  localparam int CAM_DROP = 16;
  // fraction bits of the world accumulator (Q2.14 times Q.24)
  localparam int SUM_FRAC = 38;
  // translation is Q12.12
  localparam int SHIFT_FRAC = 12;
  localparam int CYCLE_LIMIT = 300000;

  // one pixel request, laid out exactly as s_axis_tdata (column in the low bits)
  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [DEPTH_W-1:0] depth;
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   column;
  } pixel_t;

  // one expected world point
  typedef struct packed {
    logic               ok;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COORD_W-1:0] wz;
    logic [COORD_W-1:0] wy;
    logic [COORD_W-1:0] wx;
  } point_t;

  // full register image
  typedef struct packed {
    logic [2:0][CFG_DATA_W-1:0] pose;
    logic [2:0][SHIFT_W-1:0]    shift;
    logic [CFG_DATA_W-1:0]      focal;
    logic [31:0]                center;
  } setup_t;

  typedef enum int {SETUP_TYPICAL, SETUP_WILD, SETUP_EXTREME} setup_kind_t;

  // mirror of the pose/intrinsics registers plus the queue of points still owed
  class point_scoreboard;
    logic [CFG_DATA_W-1:0] pose [3];
    logic [SHIFT_W-1:0]    shift [3];
    logic [CFG_DATA_W-1:0] focal;
    logic [31:0]           center;
    point_t                awaited [$];
    int unsigned           faults;

    function new();
      pose[0] = POSE_X_RST;
      pose[1] = POSE_Y_RST;
      pose[2] = POSE_Z_RST;
      for (int r = 0; r < 3; r++) shift[r] = '0;
      focal  = '0;
      center = '0;
      faults = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_POSE_ROW_X:        pose[0] = value;
        CFG_POSE_ROW_Y:        pose[1] = value;
        CFG_POSE_ROW_Z:        pose[2] = value;
        CFG_SHIFT_X:           shift[0] = value[SHIFT_W-1:0];
        CFG_SHIFT_Y:           shift[1] = value[SHIFT_W-1:0];
        CFG_SHIFT_Z:           shift[2] = value[SHIFT_W-1:0];
        CFG_FOCAL_RECIPROCALS: focal = value;
        CFG_PRINCIPAL_POINT:   center = value[31:0];
        default: ;
      endcase
    endfunction

    // round half up: add half an lsb, then floor
    function longint round_q(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function point_t project_pixel(pixel_t px);
      point_t res;
      longint d, du, dv, acc, lim;
      longint cam [3];
      longint w [3];
      res = '0;
      d = longint'(px.depth);
      // zero depth or beyond ten meters gives an all-zero point
      if (d == 0 || d > longint'(DEPTH_MAX)) return res;
      du = longint'(px.column) * 16 - longint'(center[15:0]);
      dv = longint'(px.row) * 16 - longint'(center[31:16]);
      // a zero reciprocal just yields a zero camera coordinate
      cam[0] = round_q(du * d * longint'(focal[RECIP_W-1:0]), CAM_DROP);
      cam[1] = round_q(dv * d * longint'(focal[2*RECIP_W-1:RECIP_W]), CAM_DROP);
      cam[2] = d * (longint'(1) <<< 12);
      lim = longint'(100) <<< COORD_BITS;
      for (int r = 0; r < 3; r++) begin
        acc = longint'($signed(shift[r])) * (longint'(1) <<< (SUM_FRAC - SHIFT_FRAC));
        for (int k = 0; k < 3; k++)
          acc += longint'($signed(pose[r][16*k +: 16])) * cam[k];
        w[r] = round_q(acc, SUM_FRAC - COORD_BITS);
        // exactly 100 m still passes
        if (w[r] > lim || w[r] < -lim) return res;
      end
      res.wx    = w[0][COORD_W-1:0];
      res.wy    = w[1][COORD_W-1:0];
      res.wz    = w[2][COORD_W-1:0];
      res.red   = px.red;
      res.green = px.green;
      res.blue  = px.blue;
      res.ok    = 1'b1;
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      awaited = {awaited, project_pixel(px)};
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        faults++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_point(logic [M_TDATA_W-1:0] data, logic flag);
      point_t want;
      if (awaited.size() == 0) begin
        faults++;
        $display("%0t: unexpected point, expected none got data %h valid %0b",
                 $time, data, flag);
        return;
      end
      want = awaited.pop_front();
      compare_field("world_x", longint'($signed(want.wx)),
                    longint'($signed(data[COORD_W-1:0])));
      compare_field("world_y", longint'($signed(want.wy)),
                    longint'($signed(data[2*COORD_W-1:COORD_W])));
      compare_field("world_z", longint'($signed(want.wz)),
                    longint'($signed(data[3*COORD_W-1:2*COORD_W])));
      compare_field("red_out", longint'(want.red),
                    longint'(data[3*COORD_W +: CHAN_W]));
      compare_field("green_out", longint'(want.green),
                    longint'(data[3*COORD_W+CHAN_W +: CHAN_W]));
      compare_field("blue_out", longint'(want.blue),
                    longint'(data[3*COORD_W+2*CHAN_W +: CHAN_W]));
      compare_field("point_valid", longint'(want.ok), longint'(flag));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  point_scoreboard board = new();

  // percent chance of an idle burst at each draw, shared by both sides
  int idle_pct = 20;
  // raised by the stimulus to ask the receiver for one long hold-off
  bit hold_ask = 1'b0;

  depth_pixel_backproject_transform dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: ends a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check every accepted point, then pick tready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        board.check_point(m_axis_tdata, m_axis_tuser[0]);
      if (hold_ask) begin
        // long stall so the pipeline backs up into the pixel input
        hold_ask  = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        hold_left = $urandom_range(1, 3) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic pixel_t pixel_of(int u, int v, int d, int b, int g, int r);
    pixel_t px;
    px.column = u[PIX_W-1:0];
    px.row    = v[PIX_W-1:0];
    px.depth  = d[DEPTH_W-1:0];
    px.blue   = b[CHAN_W-1:0];
    px.green  = g[CHAN_W-1:0];
    px.red    = r[CHAN_W-1:0];
    return px;
  endfunction

  // mostly camera-sized frames and valid depths, some full-range noise
  function automatic pixel_t draw_pixel();
    pixel_t px;
    int pick;
    bit wide;
    wide = ($urandom_range(9) < 3);
    px.column = wide ? PIX_W'($urandom) : PIX_W'($urandom_range(1279));
    px.row    = wide ? PIX_W'($urandom) : PIX_W'($urandom_range(959));
    pick = $urandom_range(19);
    if (pick < 15)      px.depth = DEPTH_W'($urandom_range(1, DEPTH_MAX));
    else if (pick < 17) px.depth = '0;
    else                px.depth = DEPTH_W'($urandom);
    px.blue  = CHAN_W'($urandom);
    px.green = CHAN_W'($urandom);
    px.red   = CHAN_W'($urandom);
    return px;
  endfunction

  // identity pose, no translation, zero intrinsics
  function automatic setup_t base_setup();
    setup_t s;
    s = '0;
    s.pose[0] = POSE_X_RST;
    s.pose[1] = POSE_Y_RST;
    s.pose[2] = POSE_Z_RST;
    return s;
  endfunction

  function automatic setup_t draw_setup(setup_kind_t kind);
    setup_t s;
    int e, f;
    logic [15:0] rot_pick [4];
    logic [23:0] shift_pick [3];
    rot_pick   = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    shift_pick = '{24'h7FFFFF, 24'h800000, 24'h000000};
    s = '0;
    case (kind)
      SETUP_TYPICAL: begin
        // near-unit diagonal with some cross terms
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++) begin
            if (r == k)
              e = ($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(3000)) - 1500;
            else
              e = int'($urandom_range(8192)) - 4096;
            s.pose[r][16*k +: 16] = e[15:0];
          end
        for (int r = 0; r < 3; r++) begin
          e = int'($urandom_range(163840)) - 81920;
          s.shift[r] = e[SHIFT_W-1:0];
        end
        f = $urandom_range(400, 2000);
        s.focal[RECIP_W-1:0] = RECIP_W'((1 << 24) / f);
        f = $urandom_range(400, 2000);
        s.focal[2*RECIP_W-1:RECIP_W] = RECIP_W'((1 << 24) / f);
        s.center[15:0]  = 16'($urandom_range(1279 * 16));
        s.center[31:16] = 16'($urandom_range(959 * 16));
      end
      SETUP_WILD: begin
        for (int r = 0; r < 3; r++) begin
          s.pose[r]  = {16'($urandom), $urandom};
          s.shift[r] = SHIFT_W'($urandom);
        end
        s.focal  = {16'($urandom), $urandom};
        s.center = $urandom;
      end
      default: begin
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++)
            s.pose[r][16*k +: 16] = rot_pick[$urandom_range(3)];
          s.shift[r] = shift_pick[$urandom_range(2)];
        end
        s.focal[RECIP_W-1:0]         = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
        s.focal[2*RECIP_W-1:RECIP_W] = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
        s.center[15:0]  = $urandom_range(1) ? 16'hFFFF : 16'h0;
        s.center[31:16] = $urandom_range(1) ? 16'hFFFF : 16'h0;
      end
    endcase
    return s;
  endfunction

  // one register write; cfg_we stays up for back-to-back writes
  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  // wait until every owed point is back, plus a few cycles of margin
  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // drains the block first, so the registers are written only while it is idle
  task automatic load_setup(input setup_t s);
    drain_points();
    put_reg(CFG_POSE_ROW_X, s.pose[0]);
    put_reg(CFG_POSE_ROW_Y, s.pose[1]);
    put_reg(CFG_POSE_ROW_Z, s.pose[2]);
    put_reg(CFG_SHIFT_X, CFG_DATA_W'(s.shift[0]));
    put_reg(CFG_SHIFT_Y, CFG_DATA_W'(s.shift[1]));
    put_reg(CFG_SHIFT_Z, CFG_DATA_W'(s.shift[2]));
    put_reg(CFG_FOCAL_RECIPROCALS, s.focal);
    put_reg(CFG_PRINCIPAL_POINT, CFG_DATA_W'(s.center));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one pixel request until taken, then maybe an idle burst
  task automatic send_pixel(input pixel_t px);
    s_axis_tdata  <= px;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    board.note_pixel(px);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin
    setup_t s;
    setup_kind_t kind;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_addr      <= CFG_POSE_ROW_X;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: identity pose, zero reciprocals so only depth matters
    send_pixel(pixel_of(0, 0, 0, 255, 255, 255));          // zero depth
    send_pixel(pixel_of(0, 0, 1, 0, 0, 0));                // smallest depth
    send_pixel(pixel_of(4095, 4095, 40960, 255, 0, 170));  // exactly ten meters
    send_pixel(pixel_of(4095, 0, 40961, 18, 52, 86));      // just past ten meters
    send_pixel(pixel_of(0, 4095, 65535, 255, 255, 255));   // largest code
    send_pixel(pixel_of(2048, 1024, 32768, 170, 85, 15));
    send_pixel(pixel_of(1365, 2730, 21845, 85, 170, 240));

    // x reciprocal only, so y collapses to zero
    s = base_setup();
    s.focal[RECIP_W-1:0] = RECIP_W'((1 << 24) / 500);
    s.center = {16'(240 * 16), 16'(320 * 16)};
    load_setup(s);
    send_pixel(pixel_of(0, 0, 40960, 1, 2, 3));
    send_pixel(pixel_of(4095, 4095, 40960, 4, 5, 6));      // far off axis, still inside 100 m
    send_pixel(pixel_of(640, 480, 20480, 7, 8, 9));
    send_pixel(pixel_of(320, 240, 4096, 10, 11, 12));      // on the optical axis
    send_pixel(pixel_of(4095, 4095, 1, 13, 14, 15));

    // world range edges: 100 m on every axis still valid
    s = base_setup();
    s.shift[0] = SHIFT_W'(409600);
    s.shift[1] = SHIFT_W'(-409600);
    s.shift[2] = SHIFT_W'(409600 - 40960);
    load_setup(s);
    send_pixel(pixel_of(100, 200, 40960, 200, 100, 50));
    send_pixel(pixel_of(100, 200, 40961, 200, 100, 50));

    // one lsb past 100 m, each axis in turn
    s = base_setup();
    s.shift[0] = SHIFT_W'(409601);
    load_setup(s);
    send_pixel(pixel_of(1, 2, 4096, 1, 1, 1));
    s = base_setup();
    s.shift[1] = SHIFT_W'(-409601);
    load_setup(s);
    send_pixel(pixel_of(3, 4, 4096, 2, 2, 2));
    s = base_setup();
    s.shift[2] = SHIFT_W'(409601 - 40960);
    load_setup(s);
    send_pixel(pixel_of(5, 6, 40960, 3, 3, 3));

    // random phases, each under its own setup
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        2, 6:    kind = SETUP_EXTREME;
        4, 7:    kind = SETUP_WILD;
        default: kind = SETUP_TYPICAL;
      endcase
      load_setup(draw_setup(kind));
      // a stretch without idling mid-run, and none at all at the end
      idle_pct = (ph == 3 || ph == 9) ? 0 : 25;
      for (int n = 0; n < 113; n++) begin
        if (ph == 1 && n == 20) hold_ask = 1'b1;
        // sender pause until everything in flight has come back
        if (ph == 5 && n == 55) drain_points();
        send_pixel(draw_pixel());
      end
    end

    drain_points();
    repeat (20) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dpbt_pkg.sv
rtl/core/dpbt_world_row.sv
rtl/core/depth_pixel_backproject_transform.sv
tb/tb_top.sv
